// ----- rtl/core/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg: shared constants and types for the serial frame deframer
// Sync and type codes, verdict codes, field widths and the CRC seed.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 7;
    localparam int VERDICT_W = 3;
    localparam int LEN_W     = 16;
    localparam int CRC_W     = 16;

    // default payload limit
    localparam int MAX_PAYLOAD_DEF = 128;

    // frame byte codes
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5A;
    localparam logic [BYTE_W-1:0] TYPE_DATA = 8'hA5;
    localparam logic [BYTE_W-1:0] TYPE_PING = 8'hA6;  // ping request, not parsed
    localparam logic [BYTE_W-1:0] TYPE_PONG = 8'hA7;

    // ping reply payload length
    localparam int PING_LEN = 8;

    // CRC-16/XMODEM
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

    // frame kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_PING = 1'b1;

    // verdict codes
    typedef logic [VERDICT_W-1:0] t_verdict;
    localparam t_verdict VERD_BUSY     = 3'd0;
    localparam t_verdict VERD_CRC_GOOD = 3'd1;
    localparam t_verdict VERD_CRC_BAD  = 3'd2;
    localparam t_verdict VERD_ABORT    = 3'd3;
    localparam t_verdict VERD_PING     = 3'd4;

    // one byte of CRC update, MSB first
    function automatic logic [CRC_W-1:0] crc_upd(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if ((r & CRC_MSB) != '0) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    // CRC over the sync and data type bytes, start of every data frame
    localparam logic [CRC_W-1:0] CRC_SEED = crc_upd(crc_upd('0, SYNC_BYTE), TYPE_DATA);

endpackage

// ----- rtl/core/sfd_in_if.sv -----
// ----------------------------------------------------------------------------
// sfd_in_if: received byte channel
// Valid/ready channel carrying one byte from the serial receiver.
// ----------------------------------------------------------------------------
interface sfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [sfd_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfd_out_if.sv -----
// ----------------------------------------------------------------------------
// sfd_out_if: payload result channel
// Valid/ready channel carrying one forwarded payload byte and its status.
// ----------------------------------------------------------------------------
interface sfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfd_pkg::BYTE_W-1:0]    payload_byte;
    logic [sfd_pkg::IDX_W-1:0]     byte_index;
    logic                          frame_kind;
    logic                          end_of_frame;
    logic [sfd_pkg::VERDICT_W-1:0] verdict;

    modport source (output valid, output payload_byte, output byte_index,
                    output frame_kind, output end_of_frame, output verdict,
                    input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input frame_kind, input end_of_frame, input verdict,
                    output ready);
endinterface

// ----- rtl/core/sfd_crc_step.sv -----
// ----------------------------------------------------------------------------
// sfd_crc_step: byte-wide CRC-16/XMODEM update
// Combinational eight-bit step of the running check, MSB first.
// ----------------------------------------------------------------------------
module sfd_crc_step (
    input  logic [sfd_pkg::CRC_W-1:0]  i_crc,
    input  logic [sfd_pkg::BYTE_W-1:0] i_byte,
    output logic [sfd_pkg::CRC_W-1:0]  o_crc
);
    import sfd_pkg::*;

    logic [CRC_W-1:0] crc_mix;

    // fold the byte into the top, then shift out eight bits
    always_comb begin
        crc_mix = i_crc ^ {i_byte, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (crc_mix[CRC_W-1]) begin
                crc_mix = {crc_mix[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc_mix = {crc_mix[CRC_W-2:0], 1'b0};
            end
        end
        o_crc = crc_mix;
    end

endmodule

// ----- rtl/core/serial_frame_deframer_crc16_core.sv -----
// A byte accepted into the input register is parsed from there; the parser loads its
// result into the result register that drives o_out.
// Throughput: one byte per cycle while no held result stalls; a byte sits in the input
// register, the parser and CRC step run on it combinationally and load the result register.
// Header bytes give no result; each payload byte gives one. A held result stalls every byte.
// Reset (synchronous, active low) returns to sync hunting and empties both registers.
// ----------------------------------------------------------------------------
// serial_frame_deframer_crc16_core: framed packet parser with CRC-16/XMODEM
// Hunts for sync, decodes type, length and check, forwards payload words
// with index, kind and end-of-frame verdict.
// ----------------------------------------------------------------------------
module serial_frame_deframer_crc16_core #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfd_in_if.sink       i_in,
    sfd_out_if.source    o_out
);
    import sfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    // parse phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_TYPE   = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;
    localparam logic [2:0] PH_CRC_HI = 3'd5;
    localparam logic [2:0] PH_DATA   = 3'd6;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] CNT_PING = CNT_W'(PING_LEN);

    // input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;

    // parser state
    logic [2:0]       r_phase,   n_phase;
    logic             r_kind,    n_kind;
    logic [LEN_W-1:0] r_exp_len, n_exp_len;
    logic [CRC_W-1:0] r_rx_crc,  n_rx_crc;
    logic [CRC_W-1:0] r_run_crc, n_run_crc;
    logic [CNT_W-1:0] r_count,   n_count;

    // result register
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte,  n_out_byte;
    logic [IDX_W-1:0]  r_out_idx,   n_out_idx;
    logic              r_out_kind,  n_out_kind;
    logic              r_out_eof,   n_out_eof;
    t_verdict          r_out_verd,  n_out_verd;
    logic              n_out_load;

    logic             proc;
    logic [CRC_W-1:0] crc_in;
    logic [CRC_W-1:0] crc_out;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W+IDX_W-1:0] idx_ext;

    // a word moves out of the input register when the result slot is free or being emptied
    assign proc       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || proc;

    // running check; data frames start from the sync/type seed
    assign crc_in = (r_phase == PH_LEN_LO) ? CRC_SEED : r_run_crc;

    sfd_crc_step u_crc (
        .i_crc  (crc_in),
        .i_byte (r_in_byte),
        .o_crc  (crc_out)
    );

    assign cnt_inc = r_count + CNT_W'(1);
    assign idx_ext = {{IDX_W{1'b0}}, r_count};

    // parser next state and result
    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_exp_len  = r_exp_len;
        n_rx_crc   = r_rx_crc;
        n_run_crc  = r_run_crc;
        n_count    = r_count;
        n_out_load = 1'b0;
        n_out_byte = r_in_byte;
        n_out_idx  = idx_ext[IDX_W-1:0];
        n_out_kind = r_kind;
        n_out_eof  = 1'b0;
        n_out_verd = VERD_BUSY;

        unique case (r_phase)
            PH_IDLE: begin
                if (r_in_byte == SYNC_BYTE) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                priority if (r_in_byte == TYPE_DATA) begin
                    n_kind  = KIND_DATA;
                    n_phase = PH_LEN_LO;
                end else if (r_in_byte == TYPE_PONG) begin
                    n_kind  = KIND_PING;
                    n_count = '0;
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_LEN_LO: begin
                n_exp_len = {{(LEN_W-BYTE_W){1'b0}}, r_in_byte};
                n_run_crc = crc_out;
                n_phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_exp_len = {r_in_byte, r_exp_len[BYTE_W-1:0]};
                n_run_crc = crc_out;
                n_phase   = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_rx_crc = {{(CRC_W-BYTE_W){1'b0}}, r_in_byte};
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_rx_crc = {r_in_byte, r_rx_crc[BYTE_W-1:0]};
                n_count  = '0;
                n_phase  = PH_DATA;
            end
            PH_DATA: begin
                n_out_load = 1'b1;
                n_count    = cnt_inc;
                if (r_kind == KIND_DATA) begin
                    n_run_crc = crc_out;
                end
                // end-of-frame checks, ping first, then limit, then length
                priority if (r_kind == KIND_PING && cnt_inc >= CNT_PING) begin
                    n_out_eof  = 1'b1;
                    n_out_verd = VERD_PING;
                    n_phase    = PH_IDLE;
                end else if (cnt_inc >= CNT_MAX) begin
                    n_out_eof  = 1'b1;
                    n_out_verd = VERD_ABORT;
                    n_phase    = PH_IDLE;
                end else if (r_kind == KIND_DATA && LEN_W'(cnt_inc) >= r_exp_len) begin
                    n_out_eof  = 1'b1;
                    n_out_verd = (crc_out == r_rx_crc) ? VERD_CRC_GOOD : VERD_CRC_BAD;
                    n_phase    = PH_IDLE;
                end else begin
                    n_out_eof  = 1'b0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_kind    <= KIND_DATA;
            r_exp_len <= '0;
            r_rx_crc  <= '0;
            r_run_crc <= '0;
            r_count   <= '0;
        end else if (proc) begin
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_exp_len <= n_exp_len;
            r_rx_crc  <= n_rx_crc;
            r_run_crc <= n_run_crc;
            r_count   <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc && n_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (proc && n_out_load) begin
            r_out_byte <= n_out_byte;
            r_out_idx  <= n_out_idx;
            r_out_kind <= n_out_kind;
            r_out_eof  <= n_out_eof;
            r_out_verd <= n_out_verd;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.payload_byte = r_out_byte;
    assign o_out.byte_index   = r_out_idx;
    assign o_out.frame_kind   = r_out_kind;
    assign o_out.end_of_frame = r_out_eof;
    assign o_out.verdict      = r_out_verd;

endmodule

// ----- tb/deframer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker: payload word predictor and scoreboard
// Watches both channels of the deframer. Every accepted received byte runs
// through a local model of the frame parser and CRC-16/XMODEM check; every
// payload word it yields is queued and matched against the block's output.
// ----------------------------------------------------------------------------
module deframer_checker
    import sfd_pkg::*;
#(
    parameter int MAX_LEN = MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [BYTE_W-1:0]    i_in_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [BYTE_W-1:0]    i_out_payload,
    input  logic [IDX_W-1:0]     i_out_index,
    input  logic                 i_out_kind,
    input  logic                 i_out_last,
    input  logic [VERDICT_W-1:0] i_out_verdict,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef enum logic [2:0] {
        HUNT, GET_TYPE, LEN_LO, LEN_HI, CHK_LO, CHK_HI, PAYLOAD
    } parse_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic              kind;
        logic              last;
        t_verdict          verdict;
    } payload_word_t;

    // parser model state
    parse_t            phase;
    logic              frame_kind;
    logic [LEN_W-1:0]  want_len;
    logic [CRC_W-1:0]  frame_crc;
    logic [CRC_W-1:0]  calc_crc;
    int unsigned       seen_count;

    payload_word_t     expected_words[$];
    payload_word_t     next_word;
    payload_word_t     got_word;
    payload_word_t     oldest;
    bit                produced;
    int                fails;

    // bit-serial CRC-16/XMODEM, MSB first
    function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = crc;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            fb = r[CRC_W-1] ^ b[k];
            r  = {r[CRC_W-2:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // one received byte through the parser; payload bytes yield a word
    task automatic parse_byte(input logic [BYTE_W-1:0] c, output bit has_word,
                              output payload_word_t w);
        has_word = 1'b0;
        w        = '0;
        case (phase)
            HUNT: begin
                if (c == SYNC_BYTE) begin
                    phase = GET_TYPE;
                end
            end
            GET_TYPE: begin
                if (c == TYPE_DATA) begin
                    frame_kind = KIND_DATA;
                    phase      = LEN_LO;
                end else if (c == TYPE_PONG) begin
                    frame_kind = KIND_PING;
                    seen_count = 0;
                    phase      = PAYLOAD;
                end else begin
                    phase = HUNT;
                end
            end
            LEN_LO: begin
                want_len = {8'h00, c};
                calc_crc = crc_next(crc_next(crc_next('0, SYNC_BYTE), TYPE_DATA), c);
                phase    = LEN_HI;
            end
            LEN_HI: begin
                want_len[15:8] = c;
                calc_crc       = crc_next(calc_crc, c);
                phase          = CHK_LO;
            end
            CHK_LO: begin
                frame_crc = {8'h00, c};
                phase     = CHK_HI;
            end
            CHK_HI: begin
                frame_crc[15:8] = c;
                seen_count      = 0;
                phase           = PAYLOAD;
            end
            PAYLOAD: begin
                w.data     = c;
                w.index    = seen_count[IDX_W-1:0];
                w.kind     = frame_kind;
                w.last     = 1'b0;
                w.verdict  = VERD_BUSY;
                seen_count = seen_count + 1;
                if (frame_kind == KIND_DATA) begin
                    calc_crc = crc_next(calc_crc, c);
                end
                // ping ends first, then the length cap, then the CRC verdict
                if (frame_kind == KIND_PING && seen_count >= PING_LEN) begin
                    w.last    = 1'b1;
                    w.verdict = VERD_PING;
                    phase     = HUNT;
                end else if (seen_count >= MAX_LEN) begin
                    w.last    = 1'b1;
                    w.verdict = VERD_ABORT;
                    phase     = HUNT;
                end else if (frame_kind == KIND_DATA && seen_count >= want_len) begin
                    w.last    = 1'b1;
                    w.verdict = (calc_crc == frame_crc) ? VERD_CRC_GOOD : VERD_CRC_BAD;
                    phase     = HUNT;
                end
                has_word = 1'b1;
            end
            default: begin
                phase = HUNT;
            end
        endcase
    endtask

    // report the first ten failures, count all of them
    task automatic note_failure(input string what, input payload_word_t e,
                                input payload_word_t a);
        if (fails < 10) begin
            $display("%0t %s: expected byte %h idx %0d kind %0d last %0d verdict %0d",
                     $realtime, what, e.data, e.index, e.kind, e.last, e.verdict);
            $display("%0t %s: actual   byte %h idx %0d kind %0d last %0d verdict %0d",
                     $realtime, what, a.data, a.index, a.kind, a.last, a.verdict);
        end
        fails = fails + 1;
    endtask

    // predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = HUNT;
            frame_kind = KIND_DATA;
            want_len   = '0;
            frame_crc  = '0;
            calc_crc   = '0;
            seen_count = 0;
            expected_words.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_byte, produced, next_word);
                if (produced) begin
                    expected_words.push_back(next_word);
                end
            end
            if (i_out_valid && i_out_ready) begin
                got_word.data    = i_out_payload;
                got_word.index   = i_out_index;
                got_word.kind    = i_out_kind;
                got_word.last    = i_out_last;
                got_word.verdict = i_out_verdict;
                if (expected_words.size() == 0) begin
                    note_failure("unexpected word", '0, got_word);
                end else begin
                    oldest = expected_words.pop_front();
                    if (oldest.data != got_word.data || oldest.index != got_word.index ||
                        oldest.kind != got_word.kind || oldest.last != got_word.last ||
                        oldest.verdict != got_word.verdict) begin
                        note_failure("word mismatch", oldest, got_word);
                    end
                end
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fails;
    end

    initial begin
        fails = 0;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: serial frame deframer with CRC-16/XMODEM
// Feeds byte streams of directed and random frames (good and bad CRC data
// frames, ping replies, overlong frames, unknown types, broken headers and
// noise) with random gaps and output stalls; the checker scores the words.
// ----------------------------------------------------------------------------
module testbench;
    import sfd_pkg::*;

    localparam int MAX_LEN      = MAX_PAYLOAD_DEF;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 590;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   items_sent;
    int   quiet_cycles;
    int   fail_count;
    int   pending;

    sfd_in_if  in_if ();
    sfd_out_if out_if ();

    serial_frame_deframer_crc16_core #(
        .MAX_PAYLOAD (MAX_LEN)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    deframer_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_if.valid),
        .i_in_ready    (in_if.ready),
        .i_in_byte     (in_if.rx_byte),
        .i_out_valid   (out_if.valid),
        .i_out_ready   (out_if.ready),
        .i_out_payload (out_if.payload_byte),
        .i_out_index   (out_if.byte_index),
        .i_out_kind    (out_if.frame_kind),
        .i_out_last    (out_if.end_of_frame),
        .i_out_verdict (out_if.verdict),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one received word, after a random gap
    task automatic send_word(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] frame[$]);
        foreach (frame[k]) begin
            send_word(frame[k]);
        end
    endtask

    // data frame; first payload byte given, the rest random
    task automatic send_data_frame(input logic [LEN_W-1:0] len, input bit good_crc,
                                   input logic [BYTE_W-1:0] first_byte);
        logic [BYTE_W-1:0] frame[$];
        logic [BYTE_W-1:0] body[$];
        logic [CRC_W-1:0]  crc;
        logic [CRC_W-1:0]  sent_crc;
        int                n_body;
        n_body = (len == 0) ? 1 : ((int'(len) > MAX_LEN) ? MAX_LEN : int'(len));
        body.push_back(first_byte);
        for (int k = 1; k < n_body; k++) begin
            body.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        crc = crc_upd(crc_upd('0, SYNC_BYTE), TYPE_DATA);
        crc = crc_upd(crc_upd(crc, len[7:0]), len[15:8]);
        foreach (body[k]) begin
            crc = crc_upd(crc, body[k]);
        end
        sent_crc = crc;
        if (!good_crc) begin
            sent_crc = CRC_W'($urandom_range(0, 65535));
            if (sent_crc == crc) begin
                sent_crc[0] = ~sent_crc[0];
            end
        end
        frame = {SYNC_BYTE, TYPE_DATA, len[7:0], len[15:8], sent_crc[7:0], sent_crc[15:8]};
        frame = {frame, body};
        send_frame(frame);
    endtask

    // ping reply, payload first byte in the low bits
    task automatic send_ping(input logic [63:0] pattern);
        logic [BYTE_W-1:0] frame[$];
        frame = {SYNC_BYTE, TYPE_PONG};
        for (int k = 0; k < PING_LEN; k++) begin
            frame.push_back(pattern[8*k +: 8]);
        end
        send_frame(frame);
    endtask

    // output side: random stall before each word
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
        end
    end

    // watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        int                pick;
        int                stop_at;
        int                n;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] frame[$];
        logic [BYTE_W-1:0] b;

        no_idle       = 1'b0;
        items_sent    = 0;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.rx_byte <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ignored noise, zero length, bad CRC, ping request, ping reply
        send_word(8'h00);
        send_word(8'hFF);
        send_data_frame(16'd0, 1'b1, 8'hFF);
        send_data_frame(16'd1, 1'b0, 8'h00);
        send_frame({SYNC_BYTE, TYPE_PING});
        send_ping(64'hAA55_FE7F_0180_FF00);

        // random frames; length at the cap, then mixed traffic
        send_data_frame(LEN_W'(MAX_LEN), 1'b1, BYTE_W'($urandom_range(0, 255)));
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(0, 5) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 55) begin
                // well-formed data frame, good CRC mostly
                if ($urandom_range(0, 9) == 0) begin
                    len = LEN_W'($urandom_range(MAX_LEN - 8, MAX_LEN - 1));
                end else begin
                    len = LEN_W'($urandom_range(0, 16));
                end
                send_data_frame(len, pick < 45, BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 70) begin
                send_ping({$urandom, $urandom});
            end else if (pick < 72) begin
                // overlong: aborted at the cap
                len = ($urandom_range(0, 1) == 0) ? LEN_W'(MAX_LEN)
                                                  : LEN_W'($urandom_range(MAX_LEN + 1, 65535));
                send_data_frame(len, 1'($urandom_range(0, 1)),
                                BYTE_W'($urandom_range(0, 255)));
            end else if (pick < 81) begin
                // unknown type after sync
                do begin
                    b = BYTE_W'($urandom_range(0, 255));
                end while (b == TYPE_DATA || b == TYPE_PONG);
                send_frame({SYNC_BYTE, b});
            end else if (pick < 90) begin
                // broken header: cut short, next bytes run on in its place
                len   = LEN_W'($urandom_range(0, 65535));
                frame = {SYNC_BYTE, TYPE_DATA, len[7:0], len[15:8],
                         8'($urandom_range(0, 255))};
                n     = $urandom_range(1, 5);
                frame = frame[0:n-1];
                send_frame(frame);
            end else begin
                // noise
                n = $urandom_range(1, 4);
                repeat (n) send_word(BYTE_W'($urandom_range(0, 255)));
            end
        end
        in_if.valid <= 1'b0;
        no_idle     = 1'b0;

        // drain: every predicted word out, then a quiet wait before the verdict
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
